[rtl/core/double_buffered_sample_batcher_defines.svh]
`ifndef DOUBLE_BUFFERED_SAMPLE_BATCHER_DEFINES_SVH
`define DOUBLE_BUFFERED_SAMPLE_BATCHER_DEFINES_SVH

// Concurrent check clocked on clk_i and silenced while rst_ni is low.
`define DBSB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form of the check above.
`define DBSB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication form.
`define DBSB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dbsb_pkg.sv]
`timescale 1ns / 1ps

package dbsb_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    ACT_STORE = 2'd0,
    ACT_RESET = 2'd1,
    ACT_FETCH = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  localparam int unsigned TIME_W    = 48;
  localparam int unsigned AXIS_W    = 16;
  localparam int unsigned SAMPLE_W  = 3 * AXIS_W;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned REM_W     = 10;

  // Division by one thousand in three 16-bit digits. A partial dividend is the running
  // remainder followed by the next digit, so it stays below 1000 * 2^16 < 2^26. Its quotient
  // digit is (part * DIV_MAGIC) >> DIV_SHIFT with DIV_MAGIC = ceil(2^36 / 1000); the
  // rounding error stays well below 1/1000 over that range, so the digit is exact.
  localparam int unsigned DIV_DIG_W  = 16;
  localparam int unsigned DIV_PART_W = REM_W + DIV_DIG_W;
  localparam int unsigned DIV_MAG_W  = 27;
  localparam logic [DIV_MAG_W-1:0] DIV_MAGIC = 27'd68719477;
  localparam int unsigned DIV_SHIFT  = 36;
  localparam int unsigned DIV_PROD_W = DIV_PART_W + DIV_MAG_W;
  localparam int unsigned DIV_STEPS  = 6;
  localparam int unsigned DIV_CNT_W  = 3;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 120;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic fetch_read;
    logic fetch_emit;
  } dbsb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic slot_zero;
    logic div_last;
    logic fetch_last;
  } dbsb_sts_t;

endpackage

[rtl/core/dbsb_ctrl.sv]
`timescale 1ns / 1ps
`include "double_buffered_sample_batcher_defines.svh"

module dbsb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [1:0]          action_i,
  input  dbsb_pkg::dbsb_sts_t sts_i,
  output dbsb_pkg::dbsb_cmd_t cmd_o
);
  import dbsb_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_FRD   = 2'd2;
  localparam logic [1:0] ST_FWAIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign s_axis_tready = (state_q == ST_IDLE) && sts_i.out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = accept;
        if (accept) begin
          if (action_i == ACT_STORE && sts_i.slot_zero) begin
            state_d = ST_DIV;
          end else if (action_i == ACT_FETCH) begin
            state_d = ST_FRD;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_FRD: begin
        cmd_o.fetch_read = 1'b1;
        state_d = ST_FWAIT;
      end
      ST_FWAIT: begin
        if (sts_i.out_free) begin
          cmd_o.fetch_emit = 1'b1;
          state_d = sts_i.fetch_last ? ST_IDLE : ST_FRD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `DBSB_ASSERT_IMP(a_ready_only_idle, s_axis_tready, state_q == ST_IDLE, "tready outside idle")
  `DBSB_ASSERT_NXT(a_div_ends, state_q == ST_DIV && sts_i.div_last, state_q == ST_IDLE,
                   "divider did not return to idle")
  `DBSB_ASSERT_NXT(a_read_then_wait, state_q == ST_FRD, state_q == ST_FWAIT,
                   "fetch read not followed by wait")

endmodule

[rtl/core/dbsb_datapath.sv]
`timescale 1ns / 1ps
`include "double_buffered_sample_batcher_defines.svh"

module dbsb_datapath #(
  parameter int unsigned PACKET_SAMPLES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          action_i,
  input  logic [dbsb_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic                                m_axis_tready,
  output logic [dbsb_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                                out_last_o,
  output logic                                out_valid_o,
  input  dbsb_pkg::dbsb_cmd_t                 cmd_i,
  output dbsb_pkg::dbsb_sts_t                 sts_o
);
  import dbsb_pkg::*;

  localparam int unsigned DEPTH = 2 * PACKET_SAMPLES;
  localparam int unsigned SW    = (PACKET_SAMPLES > 1) ? $clog2(PACKET_SAMPLES) : 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Input fields.
  logic [SAMPLE_W-1:0] in_smp;
  logic                in_ok;
  logic [TIME_W-1:0]   in_now;

  assign in_smp = {in_data_i[15:0], in_data_i[31:16], in_data_i[47:32]};
  assign in_ok  = in_data_i[48];
  assign in_now = in_data_i[96:49];

  // Sample buffers and entry valid bits.
  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]    vld_q, vld_d;
  logic [SAMPLE_W-1:0] rd_data_q;
  logic                rd_vld_q;

  // Control and bookkeeping.
  logic [SAMPLE_W-1:0] held_q, held_d;
  logic                wsel_q, wsel_d;
  logic [SW-1:0]       fill_q, fill_d;
  logic [STAMP_W-1:0]  pcnt_q, pcnt_d;
  logic                ready_q, ready_d;
  logic [TIME_W-1:0]   origin_q, origin_d;
  logic [STAMP_W-1:0]  start_q [2];
  logic [STAMP_W-1:0]  start_d [2];
  logic [STAMP_W-1:0]  pnum_q [2];
  logic [STAMP_W-1:0]  pnum_d [2];
  logic [SW-1:0]       idx_q, idx_d;
  logic                rbuf_q, rbuf_d;

  // Divider by one thousand, one 16-bit quotient digit at a time: a reciprocal multiply
  // gives the digit, then a multiply-subtract gives the remainder for the next one.
  logic [TIME_W-1:0]     div_num_q, div_num_d;
  logic [REM_W-1:0]      div_rem_q, div_rem_d;
  logic [DIV_DIG_W-1:0]  div_dig_q, div_dig_d;
  logic [STAMP_W-1:0]    div_quo_q, div_quo_d;
  logic [DIV_CNT_W-1:0]  div_cnt_q, div_cnt_d;
  logic                  div_buf_q, div_buf_d;
  logic [DIV_PART_W-1:0] div_part;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [DIV_PART_W-1:0] div_back;
  logic [DIV_PART_W-1:0] div_left;
  logic [STAMP_W-1:0]    quo_next;

  // Output register.
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_last_q, out_last_d;
  logic                  out_valid_q, out_valid_d;

  logic [SW:0]           fill_inc;
  logic                  fill_full;
  logic [SAMPLE_W-1:0]   new_held;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic                  is_store;
  logic                  out_free;
  logic                  fetch_last;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign fetch_last = (idx_q == SW'(PACKET_SAMPLES - 1));
  assign is_store   = cmd_i.accept && (action_i == ACT_STORE);

  assign fill_inc  = (SW + 1)'(fill_q) + (SW + 1)'(1);
  assign fill_full = (fill_inc == (SW + 1)'(PACKET_SAMPLES));
  assign new_held  = in_ok ? in_smp : held_q;
  assign wr_en     = is_store;
  assign wr_addr   = wsel_q ? AW'(PACKET_SAMPLES) + AW'(fill_q) : AW'(fill_q);
  assign rd_addr   = rbuf_q ? AW'(PACKET_SAMPLES) + AW'(idx_q) : AW'(idx_q);

  assign div_part = {div_rem_q, div_num_q[TIME_W-1 -: DIV_DIG_W]};
  assign div_prod = DIV_PROD_W'(div_part) * DIV_PROD_W'(DIV_MAGIC);
  assign div_back = DIV_PART_W'(div_dig_q) * DIV_PART_W'(US_PER_MS);
  assign div_left = div_part - div_back;
  assign quo_next = {div_quo_q[STAMP_W-DIV_DIG_W-1:0], div_dig_q};

  always_comb begin
    held_d      = held_q;
    wsel_d      = wsel_q;
    fill_d      = fill_q;
    pcnt_d      = pcnt_q;
    ready_d     = ready_q;
    origin_d    = origin_q;
    start_d     = start_q;
    pnum_d      = pnum_q;
    idx_d       = idx_q;
    rbuf_d      = rbuf_q;
    vld_d       = vld_q;
    div_num_d   = div_num_q;
    div_rem_d   = div_rem_q;
    div_dig_d   = div_dig_q;
    div_quo_d   = div_quo_q;
    div_cnt_d   = div_cnt_q;
    div_buf_d   = div_buf_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    if (cmd_i.accept) begin
      case (action_i)
        ACT_STORE: begin
          held_d         = new_held;
          vld_d[wr_addr] = 1'b1;
          if (fill_q == '0) begin
            pnum_d[wsel_q] = pcnt_q;
            div_num_d      = in_now - origin_q;
            div_rem_d      = '0;
            div_cnt_d      = '0;
            div_buf_d      = wsel_q;
          end
          if (fill_full) begin
            fill_d  = '0;
            pcnt_d  = pcnt_q + STAMP_W'(1);
            ready_d = 1'b1;
            wsel_d  = !wsel_q;
          end else begin
            fill_d = fill_inc[SW-1:0];
          end
          out_data_d  = {7'd0, fill_full | ready_q, 64'd0, new_held[15:0],
                         new_held[31:16], new_held[47:32]};
          out_last_d  = 1'b1;
          out_valid_d = 1'b1;
        end
        ACT_RESET: begin
          pcnt_d      = '0;
          fill_d      = '0;
          wsel_d      = 1'b0;
          ready_d     = 1'b0;
          origin_d    = in_now;
          out_data_d  = {7'd0, 1'b0, 64'd0, held_q[15:0], held_q[31:16], held_q[47:32]};
          out_last_d  = 1'b1;
          out_valid_d = 1'b1;
        end
        ACT_FETCH: begin
          ready_d = 1'b0;
          idx_d   = '0;
          rbuf_d  = !wsel_q;
        end
        default: begin
          out_data_d  = {7'd0, ready_q, 64'd0, held_q[15:0], held_q[31:16], held_q[47:32]};
          out_last_d  = 1'b1;
          out_valid_d = 1'b1;
        end
      endcase
    end

    if (cmd_i.div_step) begin
      div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
      if (!div_cnt_q[0]) begin
        div_dig_d = div_prod[DIV_SHIFT +: DIV_DIG_W];
      end else begin
        div_rem_d = div_left[REM_W-1:0];
        div_num_d = {div_num_q[TIME_W-DIV_DIG_W-1:0], {DIV_DIG_W{1'b0}}};
        div_quo_d = quo_next;
        // Only the low 32 bits of the quotient are kept, which truncates the stamp.
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          start_d[div_buf_q] = quo_next;
        end
      end
    end

    if (cmd_i.fetch_emit) begin
      out_data_d = {7'd0, 1'b0, pnum_q[rbuf_q], start_q[rbuf_q],
                    rd_vld_q ? rd_data_q[15:0]  : 16'd0,
                    rd_vld_q ? rd_data_q[31:16] : 16'd0,
                    rd_vld_q ? rd_data_q[47:32] : 16'd0};
      out_last_d  = fetch_last;
      out_valid_d = 1'b1;
      idx_d       = fetch_last ? '0 : idx_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= new_held;
    end
    if (cmd_i.fetch_read) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      wsel_q      <= 1'b0;
      fill_q      <= '0;
      pcnt_q      <= '0;
      ready_q     <= 1'b0;
      origin_q    <= '0;
      start_q     <= '{default: '0};
      pnum_q      <= '{default: '0};
      idx_q       <= '0;
      rbuf_q      <= 1'b0;
      vld_q       <= '0;
      div_cnt_q   <= '0;
      div_buf_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      wsel_q      <= wsel_d;
      fill_q      <= fill_d;
      pcnt_q      <= pcnt_d;
      ready_q     <= ready_d;
      origin_q    <= origin_d;
      start_q     <= start_d;
      pnum_q      <= pnum_d;
      idx_q       <= idx_d;
      rbuf_q      <= rbuf_d;
      vld_q       <= vld_d;
      div_cnt_q   <= div_cnt_d;
      div_buf_q   <= div_buf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_num_q  <= div_num_d;
    div_rem_q  <= div_rem_d;
    div_dig_q  <= div_dig_d;
    div_quo_q  <= div_quo_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.out_free   = out_free;
  assign sts_o.slot_zero  = (fill_q == '0);
  assign sts_o.div_last   = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts_o.fetch_last = fetch_last;

  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;
  assign out_valid_o = out_valid_q;

  `DBSB_ASSERT(a_fill_range, int'(fill_q) < int'(PACKET_SAMPLES), "fill count out of range")
  `DBSB_ASSERT(a_idx_range, int'(idx_q) < int'(PACKET_SAMPLES), "fetch index out of range")
  `DBSB_ASSERT_IMP(a_emit_no_overwrite, cmd_i.fetch_emit || cmd_i.accept, out_free,
                   "output register overwritten")

endmodule

[rtl/core/double_buffered_sample_batcher.sv]
`timescale 1ns / 1ps
// Store, reset-counters and no-op items: one transfer, in the output register the cycle after
// the input transfer; the first store of a packet then keeps tready low while the divider runs.
// Fetch: PACKET_SAMPLES transfers, each a buffer read and then an output load that waits for
// a free output register; no new item is accepted until the last one is loaded.
// rst_ni is asynchronous and active low; it clears counters, stamps and entry valid bits,
// so every buffer entry reads as zero until it is written.
module double_buffered_sample_batcher #(
  parameter int unsigned PACKET_SAMPLES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input side.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // From bit 0: sample_x[15:0], sample_y[31:16], sample_z[47:32], read_ok[48],
  // now_us[96:49], zero fill[103:97].
  input  logic [103:0] s_axis_tdata,
  // action[1:0]: store sample, reset counters, fetch batch, no-op.
  input  logic [1:0]   s_axis_tuser,
  // Output side.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // From bit 0: out_x[15:0], out_y[31:16], out_z[47:32], timestamp_ms[79:48],
  // packet_seq[111:80], ready_flag[112], zero fill[119:113].
  output logic [119:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import dbsb_pkg::*;

  dbsb_cmd_t cmd;
  dbsb_sts_t sts;

  // The controller sequences the item: accept, divider steps for the packet start time,
  // and the read/emit pairs of a fetch. It only accepts in idle with the output free.
  dbsb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .action_i      (s_axis_tuser),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // The datapath holds both packet buffers, the stamps, the counters, the three-digit
  // divider that turns microseconds into milliseconds, and the output register.
  dbsb_datapath #(
    .PACKET_SAMPLES (PACKET_SAMPLES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (s_axis_tuser),
    .in_data_i     (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast),
    .out_valid_o   (m_axis_tvalid),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

[sim/dbsb_checker.sv]
`timescale 1ns / 1ps

module dbsb_checker #(
  parameter int unsigned PACKET_SAMPLES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [103:0] in_data_i,
  input  logic [1:0]  in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [119:0] out_data_i,
  input  logic        out_last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import dbsb_pkg::*;

  // One expected output transfer. The axes keep the bus layout: x, y, z from bit 0.
  typedef struct packed {
    logic [SAMPLE_W-1:0] axes;
    logic [STAMP_W-1:0]  stamp_ms;
    logic [31:0]         seq;
    logic                rdy;
    logic                fin;
  } batch_xfer_t;

  // Shadow copy of the batcher state.
  logic [SAMPLE_W-1:0] entry_mem [2*PACKET_SAMPLES];
  logic [STAMP_W-1:0]  start_ms [2];
  logic [31:0]         packet_id [2];
  logic                wr_buf;
  int unsigned         fill;
  logic [31:0]         packet_cnt;
  logic                full_pending;
  logic [TIME_W-1:0]   origin_us;
  logic [SAMPLE_W-1:0] last_good;

  batch_xfer_t expected_xfers [$];
  batch_xfer_t want;
  int unsigned errors = 0;

  assign fail_count_o = errors;

  function automatic batch_xfer_t make_xfer(input logic [SAMPLE_W-1:0] axes,
                                            input logic [STAMP_W-1:0] stamp_ms,
                                            input logic [31:0] seq,
                                            input logic rdy, input logic fin);
    batch_xfer_t x;
    x.axes     = axes;
    x.stamp_ms = stamp_ms;
    x.seq      = seq;
    x.rdy      = rdy;
    x.fin      = fin;
    return x;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic clear_state();
    foreach (entry_mem[i]) entry_mem[i] = '0;
    start_ms[0]  = '0;
    start_ms[1]  = '0;
    packet_id[0] = '0;
    packet_id[1] = '0;
    wr_buf       = 1'b0;
    fill         = 0;
    packet_cnt   = '0;
    full_pending = 1'b0;
    origin_us    = '0;
    last_good    = '0;
    expected_xfers.delete();
  endtask

  // Applies one accepted item to the shadow state and queues the transfers it causes.
  task automatic predict_item(input logic [1:0] kind, input logic [IN_DATA_W-1:0] data);
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] elapsed_ms;
    logic              rd_buf;
    int unsigned       slot;
    now_us = data[96:49];
    case (action_e'(kind))
      ACT_STORE: begin
        slot = fill % PACKET_SAMPLES;
        if (slot == 0) begin
          // The subtraction wraps at 48 bits when the clock is behind the origin.
          elapsed_ms         = (now_us - origin_us) / US_PER_MS;
          start_ms[wr_buf]   = elapsed_ms[STAMP_W-1:0];
          packet_id[wr_buf]  = packet_cnt;
        end
        if (data[48]) last_good = data[SAMPLE_W-1:0];
        entry_mem[int'(wr_buf) * PACKET_SAMPLES + slot] = last_good;
        slot++;
        if (slot >= PACKET_SAMPLES) begin
          slot         = 0;
          packet_cnt   = packet_cnt + 1;
          full_pending = 1'b1;
          wr_buf       = ~wr_buf;
        end
        fill = slot;
        expected_xfers.push_back(make_xfer(last_good, '0, '0, full_pending, 1'b1));
      end
      ACT_RESET: begin
        packet_cnt   = '0;
        fill         = 0;
        wr_buf       = 1'b0;
        full_pending = 1'b0;
        origin_us    = now_us;
        expected_xfers.push_back(make_xfer(last_good, '0, '0, full_pending, 1'b1));
      end
      ACT_FETCH: begin
        rd_buf       = ~wr_buf;
        full_pending = 1'b0;
        for (int k = 0; k < PACKET_SAMPLES; k++) begin
          expected_xfers.push_back(make_xfer(entry_mem[int'(rd_buf) * PACKET_SAMPLES + k],
                                             start_ms[rd_buf], packet_id[rd_buf], 1'b0,
                                             k == PACKET_SAMPLES - 1));
        end
      end
      default: begin
        expected_xfers.push_back(make_xfer(last_good, '0, '0, full_pending, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      pending_o <= 0;
    end else begin
      // Outputs seen at this edge belong to items accepted earlier, so check before predicting.
      if (out_valid_i && out_ready_i) begin
        if (expected_xfers.size() == 0) begin
          $error("output transfer 0x%0h with no expected result", out_data_i);
          errors++;
        end else begin
          want = expected_xfers.pop_front();
          check_field("out_x", want.axes[15:0], out_data_i[15:0]);
          check_field("out_y", want.axes[31:16], out_data_i[31:16]);
          check_field("out_z", want.axes[47:32], out_data_i[47:32]);
          check_field("timestamp_ms", want.stamp_ms, out_data_i[79:48]);
          check_field("packet_seq", want.seq, out_data_i[111:80]);
          check_field("ready_flag", want.rdy, out_data_i[112]);
          check_field("last", want.fin, out_last_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_item(in_user_i, in_data_i);
      pending_o <= expected_xfers.size();
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

// Testbench top for the ping-pong sample batcher. It only produces stimulus and the verdict;
// the checker beside the block predicts and compares every output transfer.
module tb_top;
  import dbsb_pkg::*;

  localparam int unsigned PACKET_SAMPLES = 16;
  localparam int unsigned RANDOM_ITEMS   = 180;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;

  // Sender bookkeeping: transfers left in the current burst, items accepted so far,
  // and the microsecond time that the random items carry.
  int unsigned       burst_left = 0;
  int unsigned       items_sent = 0;
  logic [TIME_W-1:0] clock_us   = '0;

  // Receiver stall pattern: a mode held for a random stretch of cycles.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always #10 clk_i = ~clk_i;

  double_buffered_sample_batcher #(
    .PACKET_SAMPLES(PACKET_SAMPLES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  dbsb_checker #(
    .PACKET_SAMPLES(PACKET_SAMPLES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_last_i  (m_axis_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // The receiver cycles through four behaviors: always ready, coin flip, mostly stalled,
  // and long stall runs broken by single ready cycles. Each one lasts a random stretch so that
  // stalls land on every phase of a fetch stream.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 128);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_left % 12 == 0);
    endcase
  end

  // Drives one item and waits for its transfer. The sender works in bursts; when a burst is
  // used up, tvalid drops for a random gap, sometimes long enough to cover the divider or a
  // whole fetch stream. The gap ends at a later edge than the one that lowered tvalid, so
  // tvalid never sees two assignments in one time step.
  task automatic send_item(input action_e act, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic ok, input logic [TIME_W-1:0] now);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 4))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, now, ok, z, y, x};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Axis values lean toward the extremes of the signed 16-bit range.
  function automatic logic [15:0] axis_value();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return r[15:0];
    endcase
  endfunction

  // Time mostly moves forward in small steps; now and then it jumps to an arbitrary 48-bit
  // value, which can also put it behind the origin and exercises the wrapped difference.
  function automatic logic [TIME_W-1:0] next_time();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    if ($urandom_range(0, 7) == 0) clock_us = r[TIME_W-1:0];
    else clock_us = clock_us + $urandom_range(1, 40000);
    return clock_us;
  endfunction

  // A sensor sample; about one read in five fails and repeats the last good sample.
  task automatic send_sample();
    send_item(ACT_STORE, axis_value(), axis_value(), axis_value(),
              $urandom_range(0, 4) != 0, next_time());
  endtask

  // Any non-store item, with random content in the fields it does not use.
  task automatic send_command(input action_e act);
    send_item(act, axis_value(), axis_value(), axis_value(), $urandom_range(0, 1), next_time());
  endtask

  initial begin
    int unsigned pick;
    int unsigned target;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A fetch straight after reset streams the all-zero buffer with zero stamps.
    send_item(ACT_FETCH, 16'h0000, 16'h0000, 16'h0000, 1'b1, 48'd0);
    // The unused action code leaves the state alone and still answers once.
    send_item(ACT_NOP, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, 48'd12345);
    // A failed read before any good one stores the zero held sample. With the origin at zero
    // and the clock at its maximum, the millisecond stamp overflows 32 bits and is truncated.
    send_item(ACT_STORE, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, 48'hFFFF_FFFF_FFFF);
    // Move the origin to the top of the 48-bit range.
    send_item(ACT_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 48'hFFFF_FFFF_FFFF);
    // One full packet. Its first sample has the clock behind the origin, so the elapsed time
    // wraps. Axis values walk through the extremes and some reads fail.
    for (int k = 0; k < PACKET_SAMPLES; k++) begin
      send_item(ACT_STORE,
                (k % 3 == 0) ? 16'h8000 : (k % 3 == 1) ? 16'h7FFF : 16'h0000,
                (k % 3 == 1) ? 16'h8000 : (k % 3 == 2) ? 16'h7FFF : 16'hFFFF,
                (k % 3 == 2) ? 16'h8000 : (k % 3 == 0) ? 16'h7FFF : 16'h0001,
                (k % 5) != 3, 48'(k) * 48'd1234567);
    end
    // The first fetch finds the batch ready, the second one repeats the same stale buffer.
    send_item(ACT_FETCH, 16'h0000, 16'h0000, 16'h0000, 1'b0, 48'd99999999);
    send_item(ACT_FETCH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 48'd0);
    send_item(ACT_NOP, 16'h0000, 16'h0000, 16'h0000, 1'b0, 48'hFFFF_FFFF_FFFF);
    // Counter reset with the origin back at zero.
    send_item(ACT_RESET, 16'h0000, 16'h0000, 16'h0000, 1'b0, 48'd0);

    // Random part: mostly whole packets followed by a fetch, plus partial packets, stray
    // fetches, counter resets and unused codes mixed in.
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat (PACKET_SAMPLES) send_sample();
        if ($urandom_range(0, 4) != 0) send_command(ACT_FETCH);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, PACKET_SAMPLES - 1)) send_sample();
      end else if (pick < 85) begin
        send_command(ACT_FETCH);
      end else if (pick < 92) begin
        send_command(ACT_RESET);
      end else begin
        send_command(ACT_NOP);
      end
    end
    s_axis_tvalid <= 1'b0;

    // One edge lets the checker count the last item, then every expected transfer drains
    // and the block gets time to show anything extra.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("double_buffered_sample_batcher regression: pass");
    end else begin
      $display("double_buffered_sample_batcher regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including worst-case stalls.
  initial begin
    #20000000;
    $display("double_buffered_sample_batcher regression: fail");
    $finish;
  end

endmodule

[double_buffered_sample_batcher.f]
+incdir+rtl/core
rtl/core/dbsb_pkg.sv
rtl/core/dbsb_ctrl.sv
rtl/core/dbsb_datapath.sv
rtl/core/double_buffered_sample_batcher.sv
sim/dbsb_checker.sv
sim/tb_top.sv
